FILE: src/isk_pkg.sv
// ============================================================================
// isk_pkg
// Shared types and defaults for the index sort-by-key block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package isk_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int ID_WIDTH      = 8;

    typedef struct packed {
        logic load;   // insert the broadcast pair
        logic drain;  // shift toward cell 0
    } isk_ctrl_t;

endpackage

`default_nettype wire

FILE: src/index_sort_by_key.sv
// ============================================================================
// index_sort_by_key
// Stable ascending sort of a batch of (id, signed key) pairs in a cell chain.
// ============================================================================
// Usage:
//   A pair transfers on a rising edge with start high and busy low. Each pair
//   is inserted into its sorted place as it transfers, so loading runs at one
//   pair per cycle while busy is low. A pair arriving with MAX_ITEMS pairs
//   held is dropped and the batch is flagged; overflow then reads 1 on all
//   its results. The pair with last_item set ends the batch: busy rises on
//   the next cycle and the chain drains one result per cycle from cell 0,
//   valid marking each transfer. The first result appears once busy is high
//   and the output registers have taken cell 0; last_out marks the final
//   one, and busy falls with it, so start may be taken in the same cycle the
//   final result shows. Equal keys come out in arrival order. The receiver
//   cannot stall: each result is on the ports for exactly one cycle.
//   Reset empties the chain, clears the count and the overflow flag.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module index_sort_by_key #(
    parameter int MAX_ITEMS = isk_pkg::MAX_ITEMS_DEF,
    parameter int KEY_WIDTH = isk_pkg::KEY_WIDTH_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire        [isk_pkg::ID_WIDTH-1:0] item_id,
    input  wire signed [KEY_WIDTH-1:0]         fitness_key,
    input  wire                                last_item,
    output logic                               valid,
    output logic       [isk_pkg::ID_WIDTH-1:0] sorted_id,
    output logic signed [KEY_WIDTH-1:0]        sorted_key,
    output logic                               last_out,
    output logic                               overflow
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic          drain_reg, drain_next;
    logic          valid_reg, valid_next;
    logic          last_out_reg, last_out_next;
    logic          overflow_reg, overflow_next;
    logic [isk_pkg::ID_WIDTH-1:0] sorted_id_reg;
    logic signed [KEY_WIDTH-1:0]  sorted_key_reg;

    logic accept;
    logic full;
    isk_pkg::isk_ctrl_t ctrl;

    logic                              cell_lt    [MAX_ITEMS];
    logic                              cell_valid [MAX_ITEMS];
    logic        [isk_pkg::ID_WIDTH-1:0] cell_id  [MAX_ITEMS];
    logic signed [KEY_WIDTH-1:0]       cell_key   [MAX_ITEMS];

    assign busy   = drain_reg;
    assign accept = start && !drain_reg;
    assign full   = (count_reg == CNT_MAX);

    assign ctrl.load  = accept && !full;
    assign ctrl.drain = drain_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic                              p_lt;
            logic                              p_valid;
            logic        [isk_pkg::ID_WIDTH-1:0] p_id;
            logic signed [KEY_WIDTH-1:0]       p_key;
            logic                              n_valid;
            logic        [isk_pkg::ID_WIDTH-1:0] n_id;
            logic signed [KEY_WIDTH-1:0]       n_key;

            if (gi == 0)
            begin : g_first
                assign p_lt    = 1'b0;
                assign p_valid = 1'b0;
                assign p_id    = '0;
                assign p_key   = '0;
            end
            else
            begin : g_mid
                assign p_lt    = cell_lt[gi-1];
                assign p_valid = cell_valid[gi-1];
                assign p_id    = cell_id[gi-1];
                assign p_key   = cell_key[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_end
                assign n_valid = 1'b0;
                assign n_id    = '0;
                assign n_key   = '0;
            end
            else
            begin : g_inner
                assign n_valid = cell_valid[gi+1];
                assign n_id    = cell_id[gi+1];
                assign n_key   = cell_key[gi+1];
            end

            isk_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_id     (item_id),
                .new_key    (fitness_key),
                .prev_lt    (p_lt),
                .prev_valid (p_valid),
                .prev_id    (p_id),
                .prev_key   (p_key),
                .next_valid (n_valid),
                .next_id    (n_id),
                .next_key   (n_key),
                .lt         (cell_lt[gi]),
                .valid      (cell_valid[gi]),
                .id         (cell_id[gi]),
                .key        (cell_key[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        drain_next    = drain_reg;
        valid_next    = 1'b0;
        last_out_next = 1'b0;
        overflow_next = 1'b0;
        if (drain_reg)
        begin
            valid_next    = 1'b1;
            last_out_next = (count_reg == CNT_ONE);
            overflow_next = dropped_reg;
            count_next    = count_reg - CNT_ONE;
            if (count_reg == CNT_ONE)
            begin
                drain_next   = 1'b0;
                dropped_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_ONE;
            end
            if (last_item)
            begin
                drain_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            drain_reg    <= 1'b0;
            valid_reg    <= 1'b0;
            last_out_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            drain_reg    <= drain_next;
            valid_reg    <= valid_next;
            last_out_reg <= last_out_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sorted_id_reg  <= cell_id[0];
        sorted_key_reg <= cell_key[0];
    end

    assign valid      = valid_reg;
    assign sorted_id  = sorted_id_reg;
    assign sorted_key = sorted_key_reg;
    assign last_out   = last_out_reg;
    assign overflow   = overflow_reg;

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (count_reg != '0) && cell_valid[0])
        else $error("drain with empty chain");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("count above capacity");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_out_reg) |-> !drain_reg)
        else $error("drain continues after final transfer");

    a_valid_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(drain_reg))
        else $error("result without drain");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(drain_reg) |-> (count_reg == '0) && !dropped_reg && !cell_valid[0])
        else $error("batch state left after drain");

endmodule

`default_nettype wire

FILE: src/isk_cell.sv
// ============================================================================
// isk_cell
// One slot of the sorting chain: holds a pair, compares it with the broadcast
// key, and takes its left neighbor, the new pair or its right neighbor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module isk_cell #(
    parameter int KEY_WIDTH = isk_pkg::KEY_WIDTH_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  isk_pkg::isk_ctrl_t                   ctrl,
    input  wire        [isk_pkg::ID_WIDTH-1:0]   new_id,
    input  wire signed [KEY_WIDTH-1:0]           new_key,
    input  wire                                  prev_lt,
    input  wire                                  prev_valid,
    input  wire        [isk_pkg::ID_WIDTH-1:0]   prev_id,
    input  wire signed [KEY_WIDTH-1:0]           prev_key,
    input  wire                                  next_valid,
    input  wire        [isk_pkg::ID_WIDTH-1:0]   next_id,
    input  wire signed [KEY_WIDTH-1:0]           next_key,
    output logic                                 lt,
    output logic                                 valid,
    output logic       [isk_pkg::ID_WIDTH-1:0]   id,
    output logic signed [KEY_WIDTH-1:0]          key
);

    logic                              valid_reg, valid_next;
    logic        [isk_pkg::ID_WIDTH-1:0] id_reg, id_next;
    logic signed [KEY_WIDTH-1:0]       key_reg, key_next;

    // empty slots act as +infinity; strict compare keeps equal keys in order
    assign lt = !valid_reg || (new_key < key_reg);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        key_next   = key_reg;
        priority if (ctrl.drain)
        begin
            valid_next = next_valid;
            id_next    = next_id;
            key_next   = next_key;
        end
        else if (ctrl.load && lt)
        begin
            if (prev_lt)
            begin
                valid_next = prev_valid;
                id_next    = prev_id;
                key_next   = prev_key;
            end
            else
            begin
                valid_next = 1'b1;
                id_next    = new_id;
                key_next   = new_key;
            end
        end
        else
        begin
            valid_next = valid_reg;
            id_next    = id_reg;
            key_next   = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign key   = key_reg;

endmodule

`default_nettype wire
